// ===== rtl/tfn_pkg.sv =====
// Shared constants for the triangle face normal pipeline.
`timescale 1ns / 1ps

package tfn_pkg;

   // Default coordinate width and normal fraction width.
   localparam int COORD_BITS_DEF       = 24;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   // Fixed formats of the result and the threshold register.
   localparam int NORMAL_BITS     = 16;
   localparam int CROSS_FRAC_BITS = 24;
   localparam int THRESH_BITS     = 32;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(1);

endpackage

// ===== rtl/tfn_sqrt_cell.sv =====
// One cell of the square root chain: settles one bit of the root per cycle while en is high.
`timescale 1ns / 1ps

module tfn_sqrt_cell #(
   parameter int LEN_BITS = 52,
   parameter int SIDE_W   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*LEN_BITS-1:0] in_rad,
   input  logic [LEN_BITS-1:0]   in_root,
   input  logic [LEN_BITS+1:0]   in_rem,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [2*LEN_BITS-1:0] out_rad,
   output logic [LEN_BITS-1:0]   out_root,
   output logic [LEN_BITS+1:0]   out_rem,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int SQ_W  = 2 * LEN_BITS;
   localparam int REM_W = LEN_BITS + 2;

   logic                valid_ff;
   logic [SQ_W-1:0]     rad_ff, rad_in;
   logic [LEN_BITS-1:0] root_ff, root_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [SIDE_W-1:0]   side_ff;
   logic [REM_W-1:0]    rem_sh;
   logic [REM_W-1:0]    trial;
   logic                fits;

   // Bring down the next two radicand bits and try the next root bit.
   always_comb begin
      rem_sh  = {in_rem[REM_W-3:0], in_rad[SQ_W-1 -: 2]};
      trial   = {in_root, 2'b01};
      fits    = (rem_sh >= trial);
      root_in = {in_root[LEN_BITS-2:0], fits};
      rem_in  = fits ? (rem_sh - trial) : rem_sh;
      rad_in  = {in_rad[SQ_W-3:0], 2'b00};
   end

   // The valid flag is control state; the data needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_root  = root_ff;
   assign out_rem   = rem_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/tfn_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit for all three lanes.
`timescale 1ns / 1ps

module tfn_div_cell #(
   parameter int RW     = 69,
   parameter int DW     = 53,
   parameter int QW     = 15,
   parameter int K      = 0,
   parameter int SIDE_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [2:0][RW-1:0]   in_rem,
   input  logic [2:0][QW-1:0]   in_q,
   input  logic [DW-1:0]        in_d,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [2:0][RW-1:0]   out_rem,
   output logic [2:0][QW-1:0]   out_q,
   output logic [DW-1:0]        out_d,
   output logic [SIDE_W-1:0]    out_side
);

   logic                valid_ff;
   logic [2:0][RW-1:0]  rem_ff, rem_in;
   logic [2:0][QW-1:0]  q_ff, q_in;
   logic [DW-1:0]       d_ff;
   logic [SIDE_W-1:0]   side_ff;
   logic [RW-1:0]       shifted_d;

   // Subtract the divisor at this bit weight where it fits.
   always_comb begin
      shifted_d = RW'(in_d) << K;
      for (int i = 0; i < 3; i++) begin
         q_in[i] = in_q[i];
         if (in_rem[i] >= shifted_d) begin
            rem_in[i]  = in_rem[i] - shifted_d;
            q_in[i][K] = 1'b1;
         end else begin
            rem_in[i] = in_rem[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         d_ff    <= in_d;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_q     = q_ff;
   assign out_d     = d_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/triangle_face_normal.sv =====
// Top level of the triangle face normal pipeline.
`timescale 1ns / 1ps

// Takes one triangle per cycle and returns one normal per triangle, in order.
// A request passes seven front stages (edges, products, cross product,
// magnitude, split squares, squares, sum), one square root cell for each
// root bit, one stage that forms the dividend and one divider cell for each
// quotient bit, then the result register. Here LEN_BITS is 2*COORD_BITS + 4
// less the wide-coordinate pre-shift. The whole pipeline stalls while a
// result waits to be taken; otherwise a new request is taken every cycle.
// The degenerate threshold may only be written while no request is in
// flight.
module triangle_face_normal #(
   parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_BITS-1:0]          req_v0_x,
   input  logic signed [COORD_BITS-1:0]          req_v0_y,
   input  logic signed [COORD_BITS-1:0]          req_v0_z,
   input  logic signed [COORD_BITS-1:0]          req_v1_x,
   input  logic signed [COORD_BITS-1:0]          req_v1_y,
   input  logic signed [COORD_BITS-1:0]          req_v1_z,
   input  logic signed [COORD_BITS-1:0]          req_v2_x,
   input  logic signed [COORD_BITS-1:0]          req_v2_y,
   input  logic signed [COORD_BITS-1:0]          req_v2_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tfn_pkg::NORMAL_BITS-1:0] rsp_normal_x,
   output logic signed [tfn_pkg::NORMAL_BITS-1:0] rsp_normal_y,
   output logic signed [tfn_pkg::NORMAL_BITS-1:0] rsp_normal_z,
   output logic                                  rsp_degenerate,
   input  logic                                  csr_wr_en,
   input  logic [tfn_pkg::THRESH_BITS-1:0]        csr_wr_data
);

   import tfn_pkg::*;

   // Derived widths.
   localparam int DW     = COORD_BITS + 1;
   localparam int PW     = 2 * DW;
   localparam int CW     = PW + 1;
   localparam int LS     = (2 * COORD_BITS > 61) ? (2 * COORD_BITS - 61) : 0;
   localparam int MW     = CW - LS;
   localparam int HL     = (MW + 1) / 2;
   localparam int HH     = MW - HL;
   localparam int SQ1    = 2 * MW;
   localparam int LEN_BITS = MW + 1;
   localparam int SQ_W   = 2 * LEN_BITS;
   localparam int REM_W  = LEN_BITS + 2;
   localparam int F      = NORMAL_FRAC_BITS;
   localparam int QW     = F + 1;
   localparam int RW     = LEN_BITS + F + 2;
   localparam int DVW    = LEN_BITS + 1;
   localparam int SHR    = (F < CROSS_FRAC_BITS) ? (CROSS_FRAC_BITS - F) : 0;
   localparam int SHL    = (F > CROSS_FRAC_BITS) ? (F - CROSS_FRAC_BITS) : 0;
   localparam int VW     = CW + SHL;
   localparam int NB     = NORMAL_BITS;
   localparam int SQ_SIDE = 3 * MW + 3 + 3 * NB;
   localparam int DV_SIDE = 3 + 3 * NB;
   localparam int TW     = THRESH_BITS + 1;
   localparam int CMPW   = (LEN_BITS > TW) ? LEN_BITS : TW;
   localparam int QX     = (QW > NB + 1) ? QW : NB + 1;

   localparam logic signed [VW-1:0] SAT_HI = VW'(2 ** (NB - 1) - 1);
   localparam logic signed [VW-1:0] SAT_LO = -VW'(2 ** (NB - 1));
   localparam logic [QX-1:0] MAG_NEG_LIM = QX'(2 ** (NB - 1));
   localparam logic [QX-1:0] MAG_POS_LIM = QX'(2 ** (NB - 1) - 1);
   localparam logic [TW-1:0] ROUND_UP   = TW'(2 ** LS - 1);

   // Global advance: the whole pipe moves unless a result is held.
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Threshold register.
   logic [THRESH_BITS-1:0] thresh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // Valid flags of the front stages.
   logic [6:0] fv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (en) begin
         fv_ff <= {fv_ff[5:0], req_valid};
      end
   end

   // Stage one: the edges A = V1 - V0 and B = V2 - V0.
   logic signed [DW-1:0] a_ff [3];
   logic signed [DW-1:0] b_ff [3];
   logic signed [DW-1:0] a_in [3];
   logic signed [DW-1:0] b_in [3];
   always_comb begin
      a_in[0] = DW'(req_v1_x) - DW'(req_v0_x);
      a_in[1] = DW'(req_v1_y) - DW'(req_v0_y);
      a_in[2] = DW'(req_v1_z) - DW'(req_v0_z);
      b_in[0] = DW'(req_v2_x) - DW'(req_v0_x);
      b_in[1] = DW'(req_v2_y) - DW'(req_v0_y);
      b_in[2] = DW'(req_v2_z) - DW'(req_v0_z);
   end

   // Stage two: the six products of the cross product.
   logic signed [PW-1:0] p_ff [6];
   logic signed [PW-1:0] p_in [6];
   always_comb begin
      p_in[0] = PW'(b_ff[1]) * PW'(a_ff[2]);
      p_in[1] = PW'(b_ff[2]) * PW'(a_ff[1]);
      p_in[2] = PW'(b_ff[2]) * PW'(a_ff[0]);
      p_in[3] = PW'(b_ff[0]) * PW'(a_ff[2]);
      p_in[4] = PW'(b_ff[0]) * PW'(a_ff[1]);
      p_in[5] = PW'(b_ff[1]) * PW'(a_ff[0]);
   end

   // Stage three: the cross product C = B x A.
   logic signed [CW-1:0] c_ff [3];
   logic signed [CW-1:0] c_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_in[i] = CW'(p_ff[2*i]) - CW'(p_ff[2*i+1]);
      end
   end

   // Stage four: magnitudes, signs and the degenerate form of each component.
   logic [MW-1:0]  m_ff [3];
   logic [MW-1:0]  m_in [3];
   logic [2:0]     sgn_ff, sgn_in;
   logic [NB-1:0]  dv_ff [3];
   logic [NB-1:0]  dv_in [3];
   logic [CW-1:0]  abs_c [3];
   logic signed [VW-1:0] shv [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sgn_in[i] = c_ff[i][CW-1];
         abs_c[i]  = sgn_in[i] ? CW'(-c_ff[i]) : CW'(c_ff[i]);
         m_in[i]   = MW'(abs_c[i] >> LS);
         shv[i]    = (VW'(c_ff[i]) <<< SHL) >>> SHR;
         if (shv[i] > SAT_HI) begin
            dv_in[i] = NB'(SAT_HI);
         end else if (shv[i] < SAT_LO) begin
            dv_in[i] = NB'(SAT_LO);
         end else begin
            dv_in[i] = NB'(shv[i]);
         end
      end
   end

   // Stage five: each square split into partial products.
   logic [2*HH-1:0]    hh_ff [3];
   logic [HH+HL-1:0]   hl_ff [3];
   logic [2*HL-1:0]    ll_ff [3];
   logic [MW-1:0]      m5_ff [3];
   logic [2:0]         sgn5_ff;
   logic [NB-1:0]      dv5_ff [3];

   // Stage six: the three squares.
   logic [SQ1-1:0]     sq_ff [3];
   logic [SQ1-1:0]     sq_in [3];
   logic [MW-1:0]      m6_ff [3];
   logic [2:0]         sgn6_ff;
   logic [NB-1:0]      dv6_ff [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (SQ1'(hh_ff[i]) << (2 * HL)) + (SQ1'(hl_ff[i]) << (HL + 1))
                    + SQ1'(ll_ff[i]);
      end
   end

   // Stage seven: the sum of squares.
   logic [SQ_W-1:0]    sum_ff, sum_in;
   logic [MW-1:0]      m7_ff [3];
   logic [2:0]         sgn7_ff;
   logic [NB-1:0]      dv7_ff [3];
   assign sum_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i]  <= a_in[i];
            b_ff[i]  <= b_in[i];
            c_ff[i]  <= c_in[i];
            m_ff[i]  <= m_in[i];
            dv_ff[i] <= dv_in[i];
            hh_ff[i] <= (2*HH)'(m_ff[i][MW-1:HL]) * (2*HH)'(m_ff[i][MW-1:HL]);
            hl_ff[i] <= (HH+HL)'(m_ff[i][MW-1:HL]) * (HH+HL)'(m_ff[i][HL-1:0]);
            ll_ff[i] <= (2*HL)'(m_ff[i][HL-1:0]) * (2*HL)'(m_ff[i][HL-1:0]);
            m5_ff[i]  <= m_ff[i];
            dv5_ff[i] <= dv_ff[i];
            sq_ff[i]  <= sq_in[i];
            m6_ff[i]  <= m5_ff[i];
            dv6_ff[i] <= dv5_ff[i];
            m7_ff[i]  <= m6_ff[i];
            dv7_ff[i] <= dv6_ff[i];
         end
         for (int i = 0; i < 6; i++) begin
            p_ff[i] <= p_in[i];
         end
         sgn_ff  <= sgn_in;
         sgn5_ff <= sgn_ff;
         sgn6_ff <= sgn5_ff;
         sgn7_ff <= sgn6_ff;
         sum_ff  <= sum_in;
      end
   end

   // Square root chain, one cell per root bit.
   logic                  sr_valid [LEN_BITS+1];
   logic [SQ_W-1:0]       sr_rad   [LEN_BITS+1];
   logic [LEN_BITS-1:0]   sr_root  [LEN_BITS+1];
   logic [REM_W-1:0]      sr_rem   [LEN_BITS+1];
   logic [SQ_SIDE-1:0]    sr_side  [LEN_BITS+1];

   assign sr_valid[0] = fv_ff[6];
   assign sr_rad[0]   = sum_ff;
   assign sr_root[0]  = '0;
   assign sr_rem[0]   = '0;
   assign sr_side[0]  = {m7_ff[2], m7_ff[1], m7_ff[0], sgn7_ff,
                         dv7_ff[2], dv7_ff[1], dv7_ff[0]};

   for (genvar j = 0; j < LEN_BITS; j++) begin : g_sqrt
      tfn_sqrt_cell #(
         .LEN_BITS (LEN_BITS),
         .SIDE_W   (SQ_SIDE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sr_valid[j]),
         .in_rad    (sr_rad[j]),
         .in_root   (sr_root[j]),
         .in_rem    (sr_rem[j]),
         .in_side   (sr_side[j]),
         .out_valid (sr_valid[j+1]),
         .out_rad   (sr_rad[j+1]),
         .out_root  (sr_root[j+1]),
         .out_rem   (sr_rem[j+1]),
         .out_side  (sr_side[j+1])
      );
   end

   // Dividend stage: each lane divides m * 2^(F+1) + L by 2L.
   logic [LEN_BITS-1:0] len_w;
   logic [MW-1:0]       sm [3];
   logic [2:0]          ssgn;
   logic [3*NB-1:0]     sdv;
   assign len_w = sr_root[LEN_BITS];
   assign {sm[2], sm[1], sm[0], ssgn, sdv} = sr_side[LEN_BITS];

   logic                dn_valid_ff;
   logic [2:0][RW-1:0]  dn_rem_ff, dn_rem_in;
   logic [DVW-1:0]      dn_d_ff;
   logic [DV_SIDE-1:0]  dn_side_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dn_rem_in[i] = (RW'(sm[i]) << (F + 1)) + RW'(len_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else if (en) begin
         dn_valid_ff <= sr_valid[LEN_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dn_rem_ff  <= dn_rem_in;
         dn_d_ff    <= {len_w, 1'b0};
         dn_side_ff <= {ssgn, sdv};
      end
   end

   // Divider chain, one cell per quotient bit from the top.
   logic                dc_valid [QW+1];
   logic [2:0][RW-1:0]  dc_rem   [QW+1];
   logic [2:0][QW-1:0]  dc_q     [QW+1];
   logic [DVW-1:0]      dc_d     [QW+1];
   logic [DV_SIDE-1:0]  dc_side  [QW+1];

   assign dc_valid[0] = dn_valid_ff;
   assign dc_rem[0]   = dn_rem_ff;
   assign dc_q[0]     = '0;
   assign dc_d[0]     = dn_d_ff;
   assign dc_side[0]  = dn_side_ff;

   for (genvar k = 0; k < QW; k++) begin : g_div
      tfn_div_cell #(
         .RW     (RW),
         .DW     (DVW),
         .QW     (QW),
         .K      (F - k),
         .SIDE_W (DV_SIDE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dc_valid[k]),
         .in_rem    (dc_rem[k]),
         .in_q      (dc_q[k]),
         .in_d      (dc_d[k]),
         .in_side   (dc_side[k]),
         .out_valid (dc_valid[k+1]),
         .out_rem   (dc_rem[k+1]),
         .out_q     (dc_q[k+1]),
         .out_d     (dc_d[k+1]),
         .out_side  (dc_side[k+1])
      );
   end

   // Final selection: unit normal, saturated raw cross product or zero.
   logic [LEN_BITS-1:0] fin_len;
   logic [2:0]          fin_sgn;
   logic [NB-1:0]       fin_dv [3];
   logic [TW-1:0]       tq;
   logic                degen;
   logic [QX-1:0]       qx [3];
   logic [QX-1:0]       mag [3];
   logic [NB-1:0]       nrm_in [3];
   logic [2:0][QW-1:0]  fin_q;

   assign fin_len = dc_d[QW][DVW-1:1];
   assign fin_q   = dc_q[QW];
   assign {fin_sgn, fin_dv[2], fin_dv[1], fin_dv[0]} = dc_side[QW];

   always_comb begin
      tq    = (TW'(thresh_ff) + ROUND_UP) >> LS;
      degen = (fin_len == '0) || (CMPW'(fin_len) < CMPW'(tq));
      for (int i = 0; i < 3; i++) begin
         qx[i] = QX'(fin_q[i]);
         if (fin_sgn[i]) begin
            mag[i] = (qx[i] > MAG_NEG_LIM) ? MAG_NEG_LIM : qx[i];
         end else begin
            mag[i] = (qx[i] > MAG_POS_LIM) ? MAG_POS_LIM : qx[i];
         end
         if (fin_len == '0) begin
            nrm_in[i] = '0;
         end else if (degen) begin
            nrm_in[i] = fin_dv[i];
         end else if (fin_sgn[i]) begin
            nrm_in[i] = NB'(-mag[i]);
         end else begin
            nrm_in[i] = NB'(mag[i]);
         end
      end
   end

   // Result register.
   logic [NB-1:0] nx_ff, ny_ff, nz_ff;
   logic          degen_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dc_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff    <= nrm_in[0];
         ny_ff    <= nrm_in[1];
         nz_ff    <= nrm_in[2];
         degen_ff <= degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = nx_ff;
   assign rsp_normal_y   = ny_ff;
   assign rsp_normal_z   = nz_ff;
   assign rsp_degenerate = degen_ff;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the triangle face normal pipeline.
`timescale 1ns / 1ps

module testbench;
   import tfn_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int NF = NORMAL_FRAC_BITS_DEF;
   localparam int LATENCY = 80;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [CB-1:0] coord_t;
   typedef logic signed [NORMAL_BITS-1:0] normal_t;

   typedef struct {
      coord_t v [9];
   } triangle_t;

   typedef struct {
      normal_t nx, ny, nz;
      logic    degen;
   } face_normal_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_t req_v [9];
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   normal_t rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;
   logic csr_wr_en = 1'b0;
   logic [THRESH_BITS-1:0] csr_wr_data = '0;

   logic [THRESH_BITS-1:0] threshold_model;
   face_normal_t expected_normals [$];
   int errors = 0;
   int checked = 0;
   int degen_seen = 0;
   int triangles_sent = 0;
   longint cycles = 0;

   initial begin
      for (int i = 0; i < 9; i++) req_v[i] = '0;
   end

   triangle_face_normal uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_v0_x(req_v[0]), .req_v0_y(req_v[1]), .req_v0_z(req_v[2]),
      .req_v1_x(req_v[3]), .req_v1_y(req_v[4]), .req_v1_z(req_v[5]),
      .req_v2_x(req_v[6]), .req_v2_y(req_v[7]), .req_v2_z(req_v[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // Cycle counter with a timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Integer square root, floor, of a value below 2^104.
   function automatic logic [63:0] root_floor(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if ({64'd0, t} * {64'd0, t} <= n) r = t;
      end
      return r;
   endfunction

   // Saturate a signed wide value to the normal range.
   function automatic normal_t clamp_normal(logic signed [127:0] v);
      if (v > 128'sd32767) return 16'sh7fff;
      if (v < -128'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Expected normal for one triangle under the current threshold.
   function automatic face_normal_t face_normal(triangle_t t);
      logic signed [127:0] ea [3], eb [3], c [3], mag [3];
      logic [127:0] sum, q;
      logic [63:0] len;
      normal_t comp [3];
      face_normal_t r;
      for (int i = 0; i < 3; i++) begin
         ea[i] = 128'(t.v[3+i]) - 128'(t.v[i]);
         eb[i] = 128'(t.v[6+i]) - 128'(t.v[i]);
      end
      c[0] = eb[1] * ea[2] - eb[2] * ea[1];
      c[1] = eb[2] * ea[0] - eb[0] * ea[2];
      c[2] = eb[0] * ea[1] - eb[1] * ea[0];
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = c[i] < 0 ? -c[i] : c[i];
         sum = sum + mag[i] * mag[i];
      end
      len = root_floor(sum);
      if (len == 0 || len < threshold_model) begin
         for (int i = 0; i < 3; i++)
            comp[i] = (len == 0) ? '0 : clamp_normal(c[i] >>> (CROSS_FRAC_BITS - NF));
         r.degen = 1'b1;
      end else begin
         // Round to nearest, ties away from zero, on the magnitude.
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << (NF + 1)) + len) / (128'(len) << 1);
            if (c[i] < 0) comp[i] = (q > 32768) ? 16'sh8000 : normal_t'(-q);
            else comp[i] = (q > 32767) ? 16'sh7fff : normal_t'(q);
         end
         r.degen = 1'b0;
      end
      r.nx = comp[0];
      r.ny = comp[1];
      r.nz = comp[2];
      return r;
   endfunction

   // Receiver stall pattern and result checking.
   logic [7:0] stall_pattern;
   initial stall_pattern = 8'b1011_0110;
   always @(posedge clock) begin
      face_normal_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_normals.size() == 0) begin
            $display("%0t: result with nothing expected, got %h %h %h %b", $time,
                     rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate);
            errors++;
         end else begin
            want = expected_normals.pop_front();
            checked++;
            if (rsp_degenerate) degen_seen++;
            if (rsp_normal_x !== want.nx) begin
               $display("%0t: normal_x expected %0d got %0d", $time, want.nx, rsp_normal_x);
               errors++;
            end
            if (rsp_normal_y !== want.ny) begin
               $display("%0t: normal_y expected %0d got %0d", $time, want.ny, rsp_normal_y);
               errors++;
            end
            if (rsp_normal_z !== want.nz) begin
               $display("%0t: normal_z expected %0d got %0d", $time, want.nz, rsp_normal_z);
               errors++;
            end
            if (rsp_degenerate !== want.degen) begin
               $display("%0t: degenerate expected %b got %b", $time, want.degen,
                        rsp_degenerate);
               errors++;
            end
         end
      end
      // Stretches with no stalling alternate with a rotating stall pattern.
      if (cycles % 2048 < 512) rsp_ready <= 1'b1;
      else begin
         stall_pattern <= {stall_pattern[6:0], stall_pattern[7] ^ stall_pattern[5]};
         rsp_ready <= stall_pattern[0] | ($urandom_range(0, 3) == 0);
      end
   end

   // Sender burst state.
   int burst_left = 0;

   // Send one triangle and record its expected normal on acceptance.
   task automatic send_triangle(triangle_t t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         // Valid drops only for a real gap between bursts.
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      for (int i = 0; i < 9; i++) req_v[i] <= t.v[i];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_normals.push_back(face_normal(t));
      triangles_sent++;
   endtask

   // Wait until every request has its result, then let the pipeline drain.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic set_threshold(logic [THRESH_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      threshold_model = value;
   endtask

   function automatic coord_t random_coord(int spread);
      case (spread)
         0: return coord_t'($urandom);
         1: return coord_t'($signed($urandom_range(0, 8191)) - 4096);
         default: return coord_t'($signed($urandom_range(0, 255)) - 128);
      endcase
   endfunction

   function automatic triangle_t random_triangle();
      triangle_t t;
      int spread;
      spread = $urandom_range(0, 2);
      for (int i = 0; i < 9; i++) t.v[i] = random_coord(spread);
      // Now and then a collinear or repeated-vertex triangle.
      if ($urandom_range(0, 15) == 0)
         for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
      return t;
   endfunction

   function automatic triangle_t make_triangle(int a0, a1, a2, b0, b1, b2, c0, c1, c2);
      triangle_t t;
      t.v = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
              coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2)};
      return t;
   endfunction

   // Directed triangles: axis planes, zero area, extremes and tiny areas.
   task automatic test_directed();
      int mx, mn;
      mx = 8388607;
      mn = -8388608;
      send_triangle(make_triangle(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
      send_triangle(make_triangle(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
      send_triangle(make_triangle(0, 0, 0, 0, 0, 4096, 0, 4096, 0));
      send_triangle(make_triangle(0, 0, 0, 4096, 0, 0, 0, 0, 4096));
      send_triangle(make_triangle(5, 5, 5, 5, 5, 5, 5, 5, 5));
      send_triangle(make_triangle(0, 0, 0, 1, 2, 3, 2, 4, 6));
      send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, -1, 0));
      send_triangle(make_triangle(mn, mn, mn, mx, mn, mn, mn, mx, mn));
      send_triangle(make_triangle(mx, mx, mx, mn, mx, mx, mx, mn, mx));
      send_triangle(make_triangle(mn, mx, mn, mx, mn, mx, mn, mn, mx));
      send_triangle(make_triangle(mx, mn, mx, mn, mx, mn, mx, mx, mn));
      send_triangle(make_triangle(-1, -1, -1, 0, 0, 0, mx, mn, -1));
      send_triangle(make_triangle(0, 0, 0, 4096, 4096, 4096, -4096, 4096, 0));
      send_triangle(make_triangle(0, 0, 0, 3, 7, 0, 5, -2, 0));
      send_triangle(make_triangle(0, 0, 0, 300, 0, 0, 0, 0, 300));
      send_triangle(make_triangle(0, 0, 0, 3000, 0, 0, 0, 0, -3000));
      send_triangle(make_triangle(-5, 0, 0, 5, 0, 0, 0, 5, 0));
      drain_pipeline();
   endtask

   task automatic test_random_batch(int count);
      for (int n = 0; n < count; n++) send_triangle(random_triangle());
      drain_pipeline();
   endtask

   // Each threshold setting, the extremes included, with random triangles.
   task automatic test_thresholds();
      set_threshold(32'd0);
      test_directed();
      test_random_batch(300);
      set_threshold(32'hffff_ffff);
      test_directed();
      test_random_batch(300);
      set_threshold(32'd1 << 24);
      test_random_batch(300);
      set_threshold(32'd1 << 12);
      test_random_batch(300);
      set_threshold($urandom);
      test_random_batch(300);
   endtask

   initial begin
      threshold_model = THRESH_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_batch(200);
      test_thresholds();
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      $display("Sent %0d triangles over several thresholds; %0d normals checked, %0d degenerate.",
               triangles_sent, checked, degen_seen);
      if (errors == 0 && expected_normals.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
